// ----- rtl/core/ipt_pkg.sv -----
// ---------------------------------------------------------------------------
// Interpolated point table reader package
// Shared codes, fixed widths and types of the point table reader.
// ---------------------------------------------------------------------------
package ipt_pkg;

   // Item codes carried in the opcode field
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   // Interpolation amount: unsigned, 16 fraction bits, one is 2^16
   localparam int                   AMOUNT_FRAC_BITS = 16;
   localparam int                   AMOUNT_BITS      = 17;
   localparam logic [AMOUNT_BITS-1:0] AMOUNT_ONE     = 17'h10000;

   // Register port geometry
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int REG_IDX_BITS  = 2;
   localparam int DIM_BITS      = 2;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_POINT_COUNT     = 2'd0,
      REG_DIMENSION_COUNT = 2'd1,
      REG_CLOSED_SHAPE    = 2'd2
   } reg_index_type;

   localparam logic [DIM_BITS-1:0] DIM_NONE = 2'd0;
   localparam logic [DIM_BITS-1:0] DIM_XY   = 2'd2;
   localparam logic [DIM_BITS-1:0] DIM_XYZ  = 2'd3;

   // Mode bits from the register block to the datapath
   typedef struct packed {
      logic [DIM_BITS-1:0] dimension_count;
      logic                closed_shape;
   } csr_mode_type;

endpackage

// ----- rtl/core/ipt_if.sv -----
// ---------------------------------------------------------------------------
// Point table reader channels
// Request channel (loads and reads) and response channel (samples).
// ---------------------------------------------------------------------------
interface ipt_req_if import ipt_pkg::*; #(
   parameter int ADDR_BITS   = 10,
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_BITS  = 26
);
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [ADDR_BITS-1:0]          point_address;
   logic signed [SAMPLE_BITS-1:0] point_x;
   logic signed [SAMPLE_BITS-1:0] point_y;
   logic signed [SAMPLE_BITS-1:0] point_z;
   logic [PHASE_BITS-1:0]         phase;
   logic [AMOUNT_BITS-1:0]        interp_amount;

   modport source (
      output valid, opcode, point_address, point_x, point_y, point_z, phase,
             interp_amount,
      input  ready
   );
   modport sink (
      input  valid, opcode, point_address, point_x, point_y, point_z, phase,
             interp_amount,
      output ready
   );
endinterface

interface ipt_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_x;
   logic signed [SAMPLE_BITS-1:0] out_y;
   logic signed [SAMPLE_BITS-1:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- rtl/core/ipt_csr.sv -----
// ---------------------------------------------------------------------------
// Point table reader registers
// APB-style register block holding point count, dimension count and shape.
// ---------------------------------------------------------------------------
module ipt_csr import ipt_pkg::*; #(
   parameter int COUNT_BITS = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [COUNT_BITS-1:0]    point_count,
   output csr_mode_type             mode
);

   logic [COUNT_BITS-1:0] point_count_ff, point_count_in;
   logic [DIM_BITS-1:0]   dimension_count_ff, dimension_count_in;
   logic                  closed_shape_ff, closed_shape_in;
   logic                  write_strobe;
   reg_index_type         reg_index;

   assign pready       = 1'b1;
   assign write_strobe = psel && penable && pwrite;
   assign reg_index    = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      point_count_in     = point_count_ff;
      dimension_count_in = dimension_count_ff;
      closed_shape_in    = closed_shape_ff;
      prdata             = '0;
      unique case (reg_index)
         REG_POINT_COUNT: begin
            prdata = CSR_DATA_BITS'(point_count_ff);
            if (write_strobe) point_count_in = pwdata[COUNT_BITS-1:0];
         end
         REG_DIMENSION_COUNT: begin
            prdata = CSR_DATA_BITS'(dimension_count_ff);
            if (write_strobe) dimension_count_in = pwdata[DIM_BITS-1:0];
         end
         REG_CLOSED_SHAPE: begin
            prdata = CSR_DATA_BITS'(closed_shape_ff);
            if (write_strobe) closed_shape_in = pwdata[0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff     <= '0;
         dimension_count_ff <= DIM_NONE;
         closed_shape_ff    <= 1'b1;
      end else begin
         point_count_ff     <= point_count_in;
         dimension_count_ff <= dimension_count_in;
         closed_shape_ff    <= closed_shape_in;
      end
   end

   assign point_count          = point_count_ff;
   assign mode.dimension_count = dimension_count_ff;
   assign mode.closed_shape    = closed_shape_ff;

endmodule

// ----- rtl/core/ipt_point_mem.sv -----
// ---------------------------------------------------------------------------
// Point table memory
// One write port and two read ports, registered read data.
// ---------------------------------------------------------------------------
module ipt_point_mem #(
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = 10,
   parameter int WORD_BITS = 48
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [WORD_BITS-1:0] rd_data_a,
   output logic [WORD_BITS-1:0] rd_data_b
);

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_a_ff, rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data while the first stage is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/core/ipt_blend.sv -----
// ---------------------------------------------------------------------------
// Point table blend lane
// Two-stage linear interpolation of one coordinate, round half up.
// ---------------------------------------------------------------------------
module ipt_blend #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          advance_mul,
   input  logic                          advance_out,
   input  logic                          lane_on,
   input  logic signed [SAMPLE_BITS-1:0] point_a,
   input  logic signed [SAMPLE_BITS-1:0] point_b,
   input  logic [FRACTION_BITS-1:0]      weight,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int PROD_BITS = SAMPLE_BITS + FRACTION_BITS + 2;
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
      PROD_BITS'(64'd1 << (FRACTION_BITS - 1));

   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [PROD_BITS-1:0]   prod_in, prod_ff;
   logic signed [SAMPLE_BITS-1:0] base_ff;
   logic signed [PROD_BITS-1:0]   rounded;
   logic signed [PROD_BITS-1:0]   shifted;
   logic signed [SAMPLE_BITS+1:0] sum;
   logic signed [SAMPLE_BITS-1:0] result_in, result_ff;

   assign diff    = (SAMPLE_BITS+1)'(point_b) - (SAMPLE_BITS+1)'(point_a);
   assign prod_in = diff * $signed({1'b0, weight});

   always_ff @(posedge clock) begin
      if (advance_mul) begin
         prod_ff <= prod_in;
         base_ff <= point_a;
      end
   end

   // Arithmetic shift floors, so the half offset rounds ties upward
   assign rounded   = prod_ff + ROUND_HALF;
   assign shifted   = rounded >>> FRACTION_BITS;
   assign sum       = (SAMPLE_BITS+2)'(base_ff) + $signed(shifted[SAMPLE_BITS+1:0]);
   assign result_in = lane_on ? sum[SAMPLE_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (advance_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/core/interpolated_point_table_reader_core.sv -----
// ---------------------------------------------------------------------------
// Interpolated point table reader
// Point table with x/y/z coordinates and a linearly interpolating read path.
// ---------------------------------------------------------------------------
// The block takes one request transfer per clock while it is not held by a
// stalled response. A load writes one point into the table at the edge of its
// transfer and gives no response; a load to an address at or beyond
// TABLE_DEPTH is dropped. A read gives one response transfer when the
// response side is ready, after the table lookup (a memory with one write and
// two read ports, so the point and its successor come out together, while the
// weight product forms beside it), the difference multipliers and rounding
// into the output register, each registered in turn. Reads keep flowing at one
// per clock as long as responses are taken; a stalled response fills the
// pipeline bubbles before the request side is held.
// A read that follows a load, even in the very next cycle, sees the loaded
// point. Reading a point that was never loaded gives undefined coordinates.
// Registers (byte address 4*i): point count (clamped to TABLE_DEPTH),
// dimension count (0 silent, 1 x, 2 x y, 3 x y z) and closed shape (when 0,
// the last point holds instead of blending toward point 0). Write registers
// only while no read is in flight.
// ---------------------------------------------------------------------------
module interpolated_point_table_reader_core import ipt_pkg::*; #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   ipt_req_if.sink                  req_bus,
   ipt_rsp_if.source                rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS = ADDR_BITS + 1;
   localparam int PHASE_BITS = ADDR_BITS + FRACTION_BITS;
   localparam int WORD_BITS  = 3 * SAMPLE_BITS;
   localparam int WPROD_BITS = FRACTION_BITS + AMOUNT_BITS;
   localparam logic [COUNT_BITS-1:0] DEPTH_COUNT = COUNT_BITS'(TABLE_DEPTH);

   // Register block
   logic [COUNT_BITS-1:0] point_count;
   csr_mode_type          mode;

   ipt_csr #(
      .COUNT_BITS (COUNT_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .point_count (point_count),
      .mode        (mode)
   );

   // Pipeline advance: each stage moves when it is empty or the next one moves
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic advance_s1, advance_s2, advance_s3;
   logic accept;

   assign advance_s3    = !s3_valid_ff || rsp_bus.ready;
   assign advance_s2    = !s2_valid_ff || advance_s3;
   assign advance_s1    = !s1_valid_ff || advance_s2;
   assign req_bus.ready = advance_s1;
   assign accept        = req_bus.valid && advance_s1;

   // Index clamp and successor with wraparound
   logic [COUNT_BITS-1:0]    count_eff;
   logic [COUNT_BITS-1:0]    count_less_one;
   logic [ADDR_BITS-1:0]     last_idx;
   logic [ADDR_BITS-1:0]     idx_raw;
   logic [ADDR_BITS-1:0]     idx;
   logic [ADDR_BITS-1:0]     next_idx;
   logic                     wraps;

   assign count_eff      = (point_count > DEPTH_COUNT) ? DEPTH_COUNT : point_count;
   assign count_less_one = count_eff - 1'b1;
   assign last_idx       = count_less_one[ADDR_BITS-1:0];
   assign idx_raw        = req_bus.phase[PHASE_BITS-1:FRACTION_BITS];
   assign idx            = (idx_raw > last_idx) ? last_idx : idx_raw;
   assign wraps          = (idx == last_idx);
   assign next_idx       = wraps ? '0 : idx + 1'b1;

   // Weight: fraction times the saturated amount, scaled back by one
   logic [FRACTION_BITS-1:0] frac;
   logic [AMOUNT_BITS-1:0]   amount_sat;
   logic [AMOUNT_BITS-1:0]   amount_eff;
   logic [WPROD_BITS-1:0]    weight_prod;
   logic [FRACTION_BITS-1:0] s1_weight_ff, s1_weight_in;

   assign frac         = req_bus.phase[FRACTION_BITS-1:0];
   assign amount_sat   = (req_bus.interp_amount > AMOUNT_ONE) ? AMOUNT_ONE
                                                              : req_bus.interp_amount;
   // Open shape: hold the last point
   assign amount_eff   = (wraps && !mode.closed_shape) ? '0 : amount_sat;
   assign weight_prod  = WPROD_BITS'(frac) * WPROD_BITS'(amount_eff);
   assign s1_weight_in = weight_prod[AMOUNT_FRAC_BITS+FRACTION_BITS-1:AMOUNT_FRAC_BITS];

   // Lane enables; all lanes silent without points or dimensions
   logic       live;
   logic [2:0] s1_mask_ff, s1_mask_in;
   logic [2:0] s2_mask_ff;

   assign live       = (mode.dimension_count != DIM_NONE) && (count_eff != '0);
   assign s1_mask_in = {live && (mode.dimension_count == DIM_XYZ),
                        live && (mode.dimension_count >= DIM_XY),
                        live};
   assign s1_valid_in = accept && (opcode_type'(req_bus.opcode) == OP_READ);

   // Table: loads write at their transfer edge, reads look up both points
   logic                 mem_wr_en;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic [WORD_BITS-1:0] word_a, word_b;

   assign mem_wr_en   = accept && (opcode_type'(req_bus.opcode) == OP_LOAD) &&
                        (COUNT_BITS'(req_bus.point_address) < DEPTH_COUNT);
   assign mem_wr_data = {req_bus.point_z, req_bus.point_y, req_bus.point_x};

   ipt_point_mem #(
      .DEPTH     (TABLE_DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_point_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (req_bus.point_address),
      .wr_data   (mem_wr_data),
      .rd_en     (advance_s1),
      .rd_addr_a (idx),
      .rd_addr_b (next_idx),
      .rd_data_a (word_a),
      .rd_data_b (word_b)
   );

   // Stage payload; hold on stall
   always_ff @(posedge clock) begin
      if (advance_s1) begin
         s1_weight_ff <= s1_weight_in;
         s1_mask_ff   <= s1_mask_in;
      end
      if (advance_s2) begin
         s2_mask_ff <= s1_mask_ff;
      end
   end

   // Stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (advance_s1) s1_valid_ff <= s1_valid_in;
         if (advance_s2) s2_valid_ff <= s1_valid_ff;
         if (advance_s3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // One blend lane per coordinate
   logic signed [SAMPLE_BITS-1:0] lane_result [3];

   for (genvar lane = 0; lane < 3; lane++) begin : g_lane
      ipt_blend #(
         .SAMPLE_BITS   (SAMPLE_BITS),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_blend (
         .clock       (clock),
         .advance_mul (advance_s2),
         .advance_out (advance_s3),
         .lane_on     (s2_mask_ff[lane]),
         .point_a     (word_a[lane*SAMPLE_BITS +: SAMPLE_BITS]),
         .point_b     (word_b[lane*SAMPLE_BITS +: SAMPLE_BITS]),
         .weight      (s1_weight_ff),
         .result      (lane_result[lane])
      );
   end

   assign rsp_bus.valid = s3_valid_ff;
   assign rsp_bus.out_x = lane_result[0];
   assign rsp_bus.out_y = lane_result[1];
   assign rsp_bus.out_z = lane_result[2];

endmodule
